>>> rtl/core/ows_pkg.sv
// Shared constants and types for the overlay window clip and scale block.
// Used by ows_div and overlay_window_clip_scale; no dependencies.
package ows_pkg;

  localparam int MAX_FRAME_DIM_DEF = 2048;

  // Divider sizes: dividend is |offset| * frame dimension, divisor is the window size
  localparam int DIV_NW = 28;
  localparam int DIV_DW = 15;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_FLIP   = 1'b1;

  localparam logic [1:0] KIND_OFF   = 2'd0;
  localparam logic [1:0] KIND_SETUP = 2'd1;
  localparam logic [1:0] KIND_PAN   = 2'd2;

  localparam logic [2:0] CFG_FRAME_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_FRAME_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_DOUBLE_BUFFER = 3'd2;
  localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } ows_div_status_t;

endpackage

>>> rtl/core/ows_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ows_pkg for widths and the status struct.
module ows_div import ows_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DIV_NW-1:0]   num,
  input  logic [DIV_DW-1:0]   den,
  output logic [DIV_NW-1:0]   quo,
  output ows_div_status_t     st
);

  localparam int CW = $clog2(DIV_NW);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} div_state_t;

  div_state_t        state_r;
  logic [CW-1:0]     cnt_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic              den_zero_r;

  logic [DIV_DW:0]   shifted;
  logic [DIV_DW+1:0] trial;

  assign shifted = {rem_r, quo_r[DIV_NW-1]};
  assign trial   = {1'b0, shifted} - {2'b0, den_r};

  assign quo     = den_zero_r ? '0 : quo_r;
  assign st.busy = (state_r == D_RUN);
  assign st.done = (state_r == D_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            quo_r      <= num;
            rem_r      <= '0;
            den_r      <= den;
            den_zero_r <= (den == '0);
            cnt_r      <= CW'(DIV_NW - 1);
            state_r    <= D_RUN;
          end
        end
        D_RUN: begin
          if (!trial[DIV_DW+1]) begin
            rem_r <= trial[DIV_DW-1:0];
            quo_r <= {quo_r[DIV_NW-2:0], 1'b1};
          end else begin
            rem_r <= shifted[DIV_DW-1:0];
            quo_r <= {quo_r[DIV_NW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= D_DONE;
          end
        end
        D_DONE: begin
          state_r <= D_IDLE;
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/overlay_window_clip_scale.sv
// Overlay window placement: clip to screen, scale edge overflow into a source crop.
// An update runs up to two divisions, one per axis.
// One item at a time: in_stall is high outside idle; the multiply and serial divider are shared by both axes.
// Flip without double buffering gives no item.
// Reset (rst_n low, synchronous): registers to 640/480/0/800/480, page and crop state to 0.
// Depends on ows_pkg and ows_div.
module overlay_window_clip_scale import ows_pkg::*; #(
  parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_win_x,
  input  logic [15:0] in_win_y,
  input  logic [14:0] in_win_w,
  input  logic [14:0] in_win_h,
  input  logic        in_show,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic        out_plane_enabled,
  output logic [14:0] out_plane_x,
  output logic [14:0] out_plane_y,
  output logic [15:0] out_plane_w,
  output logic [15:0] out_plane_h,
  output logic [18:0] out_crop_w,
  output logic [18:0] out_crop_h,
  output logic [17:0] out_crop_x,
  output logic [17:0] out_crop_y,
  output logic        out_geometry_changed
);

  localparam logic [12:0] MAX_DIM = 13'(MAX_FRAME_DIM);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_MUL, S_DIV_START, S_DIV_WAIT, S_FINISH
  } state_t;

  state_t      state_r;

  logic [11:0] frame_width_r;
  logic [11:0] frame_height_r;
  logic        double_buffer_r;
  logic [12:0] screen_width_r;
  logic [12:0] screen_height_r;

  logic        cur_page_r;
  logic [18:0] left_crop_r;
  logic [18:0] top_crop_r;
  logic [18:0] last_crop_w_r;
  logic [18:0] last_crop_h_r;
  logic [18:0] last_crop_x_r;
  logic [18:0] last_crop_y_r;

  logic [15:0] x_r, y_r;
  logic [14:0] w_r, h_r;
  logic        show_r;
  logic [1:0]  res_kind_r;
  logic        axis_r;
  logic        neg_r, sgn_r;
  logic [DIV_NW-1:0] prod_r;

  logic [18:0] xo_r, yo_r, cw_r, ch_r;
  logic [14:0] px_r, py_r;
  logic [15:0] pw_r, ph_r;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic        out_plane_enabled_r;
  logic [14:0] out_plane_x_r, out_plane_y_r;
  logic [15:0] out_plane_w_r, out_plane_h_r;
  logic [18:0] out_crop_w_r, out_crop_h_r;
  logic [17:0] out_crop_x_r, out_crop_y_r;
  logic        out_geometry_changed_r;

  // effective frame sizes
  logic [11:0] fw_m, fh_m, xv, fh;
  logic [12:0] yv;

  assign fw_m = {frame_width_r[11:4], 4'b0};
  assign fh_m = {frame_height_r[11:4], 4'b0};
  assign xv   = ({1'b0, fw_m} > MAX_DIM) ? MAX_DIM[11:0] : fw_m;
  assign fh   = ({1'b0, fh_m} > MAX_DIM) ? MAX_DIM[11:0] : fh_m;
  assign yv   = double_buffer_r ? {fh, 1'b0} : {1'b0, fh};

  logic accept, disabled;

  assign accept   = in_valid && !in_stall;
  assign disabled = (x_r == '0 && y_r == '0 && w_r == '0 && h_r == '0) ||
                    (w_r < 15'(xv[11:2])) || (h_r < 15'(yv[12:2])) ||
                    (w_r > {xv, 3'b0}) || ({1'b0, h_r} > {yv, 3'b0});

  // per-axis datapath, shared between x and y
  logic [15:0] a_pos;
  logic [14:0] a_len;
  logic [12:0] a_dim, a_scr;
  logic        a_neg, a_over, a_sgn, a_need;
  logic [15:0] a_sum;
  logic [16:0] a_diff, a_negpos, a_mag;
  logic [29:0] a_prod;
  logic [18:0] a_off, a_size;
  logic [14:0] a_ppos;
  logic [15:0] a_plen;

  assign a_pos    = axis_r ? y_r : x_r;
  assign a_len    = axis_r ? h_r : w_r;
  assign a_dim    = axis_r ? yv : {1'b0, xv};
  assign a_scr    = axis_r ? screen_height_r : screen_width_r;
  assign a_neg    = a_pos[15];
  assign a_sum    = {1'b0, a_pos[14:0]} + {1'b0, a_len};
  assign a_over   = !a_neg && (a_sum > {3'b0, a_scr});
  assign a_diff   = {4'b0, a_scr} - {1'b0, a_pos};
  assign a_negpos = 17'd0 - {a_pos[15], a_pos};
  assign a_mag    = a_neg ? a_negpos : (a_diff[16] ? (17'd0 - a_diff) : a_diff);
  assign a_sgn    = !a_neg && a_diff[16];
  assign a_need   = (a_len != {2'b0, a_dim}) && (a_neg || a_over);
  assign a_prod   = {13'b0, a_mag} * {17'b0, a_dim};

  assign a_off    = a_neg ? {2'b0, a_mag} : '0;
  assign a_size   = a_neg  ? ({6'b0, a_dim} - {2'b0, a_mag}) :
                    a_over ? {{2{a_diff[16]}}, a_diff} : {6'b0, a_dim};
  assign a_ppos   = a_neg ? '0 : a_pos[14:0];
  assign a_plen   = a_neg  ? (a_pos + {1'b0, a_len}) :
                    a_over ? a_diff[15:0] : {1'b0, a_len};

  // shared divider
  logic              div_start;
  logic [DIV_NW-1:0] div_quo;
  ows_div_status_t   div_st;
  logic [18:0]       q;
  logic [18:0]       q_size;

  assign div_start = (state_r == S_DIV_START);
  assign q         = div_quo[18:0];
  assign q_size    = neg_r ? ({6'b0, a_dim} - q) : (sgn_r ? (19'd0 - q) : q);

  ows_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (a_len),
    .quo   (div_quo),
    .st    (div_st)
  );

  // result assembly
  logic [18:0] xo_even, cw_even, cy_upd, cy_flip;
  logic [11:0] page_base;
  logic        changed, out_free, fin_go, is_pan, is_setup;

  assign xo_even   = xo_r + {18'b0, xo_r[0]};
  assign cw_even   = {cw_r[18:1], 1'b0};
  assign page_base = cur_page_r ? fh : '0;
  assign cy_upd    = {7'b0, page_base} + yo_r;
  assign cy_flip   = {7'b0, page_base} + top_crop_r;
  assign changed   = (cw_even != last_crop_w_r) || (ch_r != last_crop_h_r) ||
                     (xo_even != last_crop_x_r) || (cy_upd != last_crop_y_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign fin_go    = (state_r == S_FINISH) && out_free;
  assign is_pan    = (res_kind_r == KIND_PAN);
  assign is_setup  = (res_kind_r == KIND_SETUP);

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      frame_width_r   <= 12'd640;
      frame_height_r  <= 12'd480;
      double_buffer_r <= 1'b0;
      screen_width_r  <= 13'd800;
      screen_height_r <= 13'd480;
      cur_page_r      <= 1'b0;
      left_crop_r     <= '0;
      top_crop_r      <= '0;
      last_crop_w_r   <= '0;
      last_crop_h_r   <= '0;
      last_crop_x_r   <= '0;
      last_crop_y_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:   frame_width_r   <= cfg_data[11:0];
          CFG_FRAME_HEIGHT:  frame_height_r  <= cfg_data[11:0];
          CFG_DOUBLE_BUFFER: double_buffer_r <= cfg_data[0];
          CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_data;
          CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && !fin_go) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            x_r    <= in_win_x;
            y_r    <= in_win_y;
            w_r    <= in_win_w;
            h_r    <= in_win_h;
            show_r <= in_show;
            if (in_cmd == CMD_FLIP) begin
              res_kind_r <= KIND_PAN;
              if (double_buffer_r) begin
                state_r <= S_FINISH;
              end
            end else begin
              state_r <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          axis_r <= 1'b0;
          if (disabled) begin
            res_kind_r <= KIND_OFF;
            state_r    <= S_FINISH;
          end else begin
            res_kind_r <= KIND_SETUP;
            state_r    <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= a_prod[DIV_NW-1:0];
          neg_r  <= a_neg;
          sgn_r  <= a_sgn;
          if (axis_r) begin
            yo_r <= a_off;
            ch_r <= a_size;
            py_r <= a_ppos;
            ph_r <= a_plen;
          end else begin
            xo_r <= a_off;
            cw_r <= a_size;
            px_r <= a_ppos;
            pw_r <= a_plen;
          end
          if (a_need) begin
            state_r <= S_DIV_START;
          end else if (axis_r) begin
            state_r <= S_FINISH;
          end else begin
            axis_r <= 1'b1;
          end
        end
        S_DIV_START: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_st.done) begin
            if (axis_r) begin
              if (neg_r) yo_r <= q;
              ch_r    <= q_size;
              state_r <= S_FINISH;
            end else begin
              if (neg_r) xo_r <= q;
              cw_r    <= q_size;
              axis_r  <= 1'b1;
              state_r <= S_MUL;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_kind_r             <= res_kind_r;
            out_plane_enabled_r    <= is_setup && show_r;
            out_plane_x_r          <= is_setup ? px_r : '0;
            out_plane_y_r          <= is_setup ? py_r : '0;
            out_plane_w_r          <= is_setup ? pw_r : '0;
            out_plane_h_r          <= is_setup ? ph_r : '0;
            out_crop_w_r           <= is_setup ? cw_even : '0;
            out_crop_h_r           <= is_setup ? ch_r : '0;
            out_crop_x_r           <= is_setup ? xo_even[17:0] :
                                      is_pan   ? left_crop_r[17:0] : '0;
            out_crop_y_r           <= is_setup ? cy_upd[17:0] :
                                      is_pan   ? cy_flip[17:0] : '0;
            out_geometry_changed_r <= is_setup && changed;
            if (is_pan) begin
              last_crop_x_r <= left_crop_r;
              last_crop_y_r <= cy_flip;
              cur_page_r    <= !cur_page_r;
            end else if (is_setup) begin
              left_crop_r   <= xo_even;
              top_crop_r    <= yo_r;
              last_crop_w_r <= cw_even;
              last_crop_h_r <= ch_r;
              last_crop_x_r <= xo_even;
              last_crop_y_r <= cy_upd;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = out_kind_r;
  assign out_plane_enabled    = out_plane_enabled_r;
  assign out_plane_x          = out_plane_x_r;
  assign out_plane_y          = out_plane_y_r;
  assign out_plane_w          = out_plane_w_r;
  assign out_plane_h          = out_plane_h_r;
  assign out_crop_w           = out_crop_w_r;
  assign out_crop_h           = out_crop_h_r;
  assign out_crop_x           = out_crop_x_r;
  assign out_crop_y           = out_crop_y_r;
  assign out_geometry_changed = out_geometry_changed_r;

`ifndef SYNTH
  a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_WAIT) |-> (div_st.busy || div_st.done))
    else $error("waiting on an idle divider");

  a_update_checked: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_UPDATE) |=> (state_r == S_CHECK))
    else $error("update item not checked");

  a_off_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_OFF) |->
      (!out_plane_enabled_r && !out_geometry_changed_r && out_crop_x_r == '0))
    else $error("disabled item carries geometry");

  a_pan_page: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free && res_kind_r == KIND_PAN) |=>
      (cur_page_r != $past(cur_page_r)))
    else $error("pan did not toggle page");
`endif

endmodule
